FILE: design/crpe_pkg.sv
// ----------------------------------------------------------------------------
// crpe_pkg
// Shared types and constants for the Catmull-Rom path evaluator.
// ----------------------------------------------------------------------------
package crpe_pkg;

   localparam int COORD_W = 32;
   localparam int ACC_W   = 72;

   typedef enum logic [1:0] {
      MODE_SPLINE = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_HOLD   = 2'd2,
      MODE_OTHER  = 2'd3
   } mode_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [5:0]          point_index;
      logic signed [31:0]  point_x;
      logic signed [31:0]  point_y;
      logic signed [31:0]  point_z;
      logic [1:0]          point_mode;
      logic [5:0]          segment;
      logic signed [31:0]  param_t;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_WAIT,
      ST_POW2,
      ST_POW3,
      ST_MAC,
      ST_DONE
   } state_type;

   // one multiply-accumulate step of the shared unit
   typedef struct packed {
      logic clear;
      logic enable;
   } mac_ctl_type;

   // saturate a wide value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(signed'(32'sh7fffffff));
      lo = -ACC_W'(64'sh80000000);
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

FILE: design/crpe_ram.sv
// ----------------------------------------------------------------------------
// crpe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module crpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/crpe_mac.sv
// ----------------------------------------------------------------------------
// crpe_mac
// Shared multiply-accumulate unit: one 36x18 signed product a cycle.
// ----------------------------------------------------------------------------
module crpe_mac
   import crpe_pkg::*;
(
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   input  logic signed [35:0]       coef,
   input  logic signed [17:0]       mult,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [53:0]      prod;

   // product and accumulate
   always_comb begin
      prod = coef * mult;
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end
      if (ctl.enable) begin
         acc_in = (ctl.clear ? '0 : acc_ff) + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: design/catmull_rom_path_evaluator.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_evaluator
// Control point table with hold, linear and Catmull-Rom evaluation.
// ----------------------------------------------------------------------------
// A write request completes in its accepting cycle. An evaluate request on the
// empty table goes straight to the done state; one point or hold mode does four
// reads from the shared point memory and two steps for the powers of t, and
// linear or spline adds one 36x18 multiply-accumulate step per term and
// coordinate through a single shared unit. busy is high for the whole
// evaluation; the result appears for one cycle with rsp_valid in the first
// cycle that busy is low and cannot be held off by the receiver.
module catmull_rom_path_evaluator
   import crpe_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  logic     csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);

   state_type state_ff, state_in;
   logic [6:0] count_ff;
   logic [NW-1:0] n_ff, n_in;
   logic [AW-1:0] seg_ff, seg_in, rd_addr;
   logic signed [17:0] u_ff, u_in, u2_ff, u3_ff;
   logic [1:0] mode_ff;
   logic signed [31:0] p_ff [4][3];
   logic [1:0] rd_cnt_ff;
   logic [3:0] step_ff, step_in;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic cap_ff;
   logic [1:0] cap_axis_ff;
   logic wr_en;
   logic [97:0] rd_word;
   logic signed [35:0] coef;
   logic signed [17:0] mult;
   mac_ctl_type mac_ctl;
   logic signed [ACC_W-1:0] acc;
   logic [1:0] axis;
   logic [1:0] term;
   logic signed [35:0] q0, q1, q2, q3;
   logic signed [35:0] pw;

   // point memory: x, y, z and mode in one word
   assign wr_en = (state_ff == ST_IDLE) && start && (req_data.cmd == CMD_WRITE)
                  && (32'(req_data.point_index) < MAX_POINTS);

   crpe_ram #(.WIDTH(98), .DEPTH(MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.point_index)),
      .wr_data ({req_data.point_x, req_data.point_y, req_data.point_z,
                 req_data.point_mode}),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // point count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // clamp count, segment and t at request time
   always_comb begin
      logic [NW:0] lim;
      n_in = (32'(count_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count_ff);
      lim = (NW+1)'(n_in) - (NW+1)'(2);
      seg_in = AW'(req_data.segment);
      if (n_in < NW'(2)) begin
         seg_in = '0;
      end else if ((NW+1)'(req_data.segment) > lim) begin
         seg_in = AW'(lim);
      end
      if (req_data.param_t < 0) begin
         u_in = '0;
      end else if (req_data.param_t > 32'sd65536) begin
         u_in = 18'sd65536;
      end else begin
         u_in = 18'(req_data.param_t);
      end
   end

   // read address for p0..p3 over the read steps
   always_comb begin
      rd_addr = seg_ff;
      case (state_ff)
         ST_RD0:  rd_addr = (seg_ff == '0) ? seg_ff : seg_ff - AW'(1);
         ST_RD1:  rd_addr = seg_ff;
         ST_RD2:  rd_addr = (n_ff < NW'(2)) ? seg_ff : seg_ff + AW'(1);
         ST_RD3:  rd_addr = ((NW+1)'(seg_ff) + (NW+1)'(2) > (NW+1)'(n_ff) - (NW+1)'(1))
                            ? AW'(n_ff - NW'(1)) : seg_ff + AW'(2);
         default: rd_addr = seg_ff;
      endcase
   end

   // per axis coefficients
   always_comb begin
      logic signed [35:0] a0, a1, a2, a3;
      a0 = 36'(p_ff[0][axis]);
      a1 = 36'(p_ff[1][axis]);
      a2 = 36'(p_ff[2][axis]);
      a3 = 36'(p_ff[3][axis]);
      q0 = a1 <<< 1;
      q1 = a2 - a0;
      q2 = (a0 <<< 1) - (a1 <<< 2) - a1 + (a2 <<< 2) - a3;
      q3 = a1 + (a1 <<< 1) - a0 - (a2 <<< 1) - a2 + a3;
      pw = u_ff * u_ff;
   end

   assign axis = 2'(step_ff >> 2);
   assign term = step_ff[1:0];

   // operand select for the shared unit
   always_comb begin
      coef = '0;
      mult = '0;
      if (mode_ff == MODE_LINEAR) begin
         coef = (term == 2'd0) ? 36'(p_ff[1][axis]) : 36'(p_ff[2][axis]);
         mult = (term == 2'd0) ? 18'sd65536 - u_ff : u_ff;
      end else begin
         case (term)
            2'd0: begin coef = q0; mult = 18'sd65536; end
            2'd1: begin coef = q1; mult = u_ff; end
            2'd2: begin coef = q2; mult = u2_ff; end
            default: begin coef = q3; mult = u3_ff; end
         endcase
      end
      mac_ctl.clear = (state_ff == ST_MAC) && (term == 2'd0);
      mac_ctl.enable = (state_ff == ST_MAC) &&
                       ((mode_ff != MODE_LINEAR) || (term < 2'd2));
   end

   crpe_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .coef  (coef),
      .mult  (mult),
      .acc   (acc)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      case (state_ff)
         ST_IDLE: if (start && req_data.cmd == CMD_EVAL) begin
            state_in = (n_in == '0) ? ST_DONE : ST_RD0;
         end
         ST_RD0: state_in = ST_RD1;
         ST_RD1: state_in = ST_RD2;
         ST_RD2: state_in = ST_RD3;
         ST_RD3: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_POW2;
         ST_POW2: state_in = ST_POW3;
         ST_POW3: begin
            step_in = '0;
            state_in = (n_ff == NW'(1) || mode_ff == MODE_HOLD) ? ST_DONE : ST_MAC;
         end
         ST_MAC: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd11) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
         // accumulator holds the full axis sum in the cycle after its last term
         cap_ff <= (state_ff == ST_MAC) && (term == 2'd3);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         n_ff <= n_in;
         seg_ff <= seg_in;
         u_ff <= u_in;
         rd_cnt_ff <= '0;
      end
      // capture read data in the cycle after each address
      if (state_ff == ST_RD1 || state_ff == ST_RD2 || state_ff == ST_RD3 ||
          state_ff == ST_WAIT) begin
         p_ff[rd_cnt_ff][0] <= rd_word[97:66];
         p_ff[rd_cnt_ff][1] <= rd_word[65:34];
         p_ff[rd_cnt_ff][2] <= rd_word[33:2];
         rd_cnt_ff <= rd_cnt_ff + 2'd1;
         if (state_ff == ST_RD2) begin
            mode_ff <= rd_word[1:0];
         end
      end
      if (state_ff == ST_POW2) begin
         u2_ff <= 18'(pw >>> 16);
      end
      if (state_ff == ST_POW3) begin
         u3_ff <= 18'((36'(u2_ff) * 36'(u_ff)) >>> 16);
      end
      cap_axis_ff <= axis;
      // result capture
      if (state_ff == ST_DONE) begin
         if (n_ff == '0) begin
            rsp_ff <= '0;
         end else if (n_ff == NW'(1) || mode_ff == MODE_HOLD) begin
            rsp_ff <= {p_ff[1][0], p_ff[1][1], p_ff[1][2]};
         end
      end
      if (cap_ff) begin
         case (cap_axis_ff)
            2'd0: rsp_ff.pos_x <= sat32(acc >>> ((mode_ff == MODE_LINEAR) ? 16 : 17));
            2'd1: rsp_ff.pos_y <= sat32(acc >>> ((mode_ff == MODE_LINEAR) ? 16 : 17));
            default: rsp_ff.pos_z <= sat32(acc >>> ((mode_ff == MODE_LINEAR) ? 16 : 17));
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE)) else $error("stray response");
   a_busy_in_mac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> busy) else $error("not busy during mac");
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy) else $error("write while busy");
`endif

endmodule
